@@ hdl/jpc_pkg.sv @@
// ----------------------------------------------------------------------------
// jpc_pkg
// Shared types, constants and character-class helpers for the JSON payload
// classifier.
// ----------------------------------------------------------------------------
package jpc_pkg;

    // Width of the position and distance counters (windows go up to 31)
    localparam int POS_W = 5;

    // Character codes
    localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
    localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
    localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
    localparam logic [7:0] CH_SPACE         = 8'h20;
    localparam logic [7:0] CH_TAB           = 8'h09;
    localparam logic [7:0] CH_CR            = 8'h0D;
    localparam logic [7:0] CH_LF            = 8'h0A;
    localparam logic [7:0] CH_TILDE         = 8'h7E;

    // Classification of one payload byte
    typedef struct packed {
        logic is_open;    // opening brace or bracket
        logic is_close;   // closing brace or bracket
        logic loose_ok;   // whitespace or alphanumeric
        logic text_ok;    // printable, tab, CR or LF
    } char_class_t;

    function automatic logic is_space_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_alnum_char(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

endpackage

@@ hdl/jpc_char_class.sv @@
// ----------------------------------------------------------------------------
// jpc_char_class
// Classifies one payload byte into the character groups used by the head
// and tail rules.
// ----------------------------------------------------------------------------
module jpc_char_class
    import jpc_pkg::*;
(
    input  logic [7:0]  data_byte,
    output char_class_t cls
);

    // Decode the byte into its groups
    always_comb begin
        cls.is_open  = (data_byte == CH_OPEN_BRACE) || (data_byte == CH_OPEN_BRACKET);
        cls.is_close = (data_byte == CH_CLOSE_BRACE) || (data_byte == CH_CLOSE_BRACKET);
        cls.loose_ok = is_space_char(data_byte) || is_alnum_char(data_byte);
        cls.text_ok  = ((data_byte >= CH_SPACE) && (data_byte <= CH_TILDE)) ||
                       (data_byte == CH_TAB) || (data_byte == CH_CR) ||
                       (data_byte == CH_LF);
    end

endmodule

@@ hdl/json_payload_classifier_core.sv @@
// ----------------------------------------------------------------------------
// json_payload_classifier_core
// Streams payload bytes and gives one verdict per payload, on its last byte,
// telling whether the payload looks like JSON.
// ----------------------------------------------------------------------------
// The verdict is valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while s_ready is high; the rule state is
// updated in one pass between the per-payload state and verdict registers.
// Reset: synchronous active-low aresetn clears the rule state and the verdict
// valid flag; state also returns to its reset value after every verdict.
// ----------------------------------------------------------------------------
module json_payload_classifier_core
    import jpc_pkg::*;
#(
    parameter int HEAD_WINDOW  = 16,
    parameter int TAIL_WINDOW  = 16,
    parameter int LOOSE_PREFIX = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_json
);

    localparam logic [POS_W-1:0] HEAD_POS  = POS_W'(HEAD_WINDOW);
    localparam logic [POS_W-1:0] TAIL_POS  = POS_W'(TAIL_WINDOW);
    localparam logic [POS_W-1:0] LOOSE_POS = POS_W'(LOOSE_PREFIX);

    char_class_t      cls;
    logic             s_accept;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             opener_reg, opener_next;
    logic             head_rej_reg, head_rej_next;
    logic             tail_bad_reg, tail_bad_next;
    logic [POS_W-1:0] since_bad_reg, since_bad_next;
    logic             m_valid_reg;
    logic             is_json_reg;
    logic             verdict;

    jpc_char_class u_char_class (
        .data_byte (s_data_byte),
        .cls       (cls)
    );

    // Take a byte whenever the verdict register is free or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Update head and tail rules for the incoming byte
    always_comb begin
        pos_next       = pos_reg;
        opener_next    = opener_reg;
        head_rej_next  = head_rej_reg;
        tail_bad_next  = tail_bad_reg;
        since_bad_next = since_bad_reg;

        if (pos_reg < HEAD_POS) begin
            if (!opener_reg) begin
                if (cls.is_open) begin
                    opener_next = 1'b1;
                end else if ((pos_reg >= LOOSE_POS) && !cls.loose_ok) begin
                    head_rej_next = 1'b1;
                end
            end
            if (opener_next && !cls.text_ok) begin
                head_rej_next = 1'b1;
            end
            pos_next = pos_reg + POS_W'(1);
        end

        if (cls.is_close) begin
            tail_bad_next  = 1'b0;
            since_bad_next = '0;
        end else if (!cls.loose_ok) begin
            tail_bad_next  = 1'b1;
            since_bad_next = '0;
        end else if (tail_bad_reg && (since_bad_reg < TAIL_POS)) begin
            since_bad_next = since_bad_reg + POS_W'(1);
        end

        verdict = (pos_reg != '0) && opener_next && !head_rej_next &&
                  !(tail_bad_next && (since_bad_next < TAIL_POS));
    end

    // Hold rule state; clear it after each verdict
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            opener_reg    <= 1'b0;
            head_rej_reg  <= 1'b0;
            tail_bad_reg  <= 1'b0;
            since_bad_reg <= '0;
        end else if (s_accept) begin
            if (s_last_byte) begin
                pos_reg       <= '0;
                opener_reg    <= 1'b0;
                head_rej_reg  <= 1'b0;
                tail_bad_reg  <= 1'b0;
                since_bad_reg <= '0;
            end else begin
                pos_reg       <= pos_next;
                opener_reg    <= opener_next;
                head_rej_reg  <= head_rej_next;
                tail_bad_reg  <= tail_bad_next;
                since_bad_reg <= since_bad_next;
            end
        end
    end

    // Verdict register: load on the last byte, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_last_byte) begin
            is_json_reg <= verdict;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_is_json = is_json_reg;

    // Checks
    a_last_gives_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_byte) |=> m_valid)
        else $error("verdict not presented after last byte");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_byte) |=> (pos_reg == '0 && !opener_reg && !head_rej_reg &&
                                       !tail_bad_reg && since_bad_reg == '0))
        else $error("rule state not cleared after verdict");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= HEAD_POS)
        else $error("byte position beyond head window");

    a_since_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        since_bad_reg <= TAIL_POS)
        else $error("tail distance beyond tail window");

    a_no_verdict_without_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !(s_accept && s_last_byte)) |=> !m_valid)
        else $error("verdict appeared without a last byte");

endmodule
